// ===== sv/etbd_pkg.sv =====
package etbd_pkg;

    localparam int CELL_STRIDE     = 4;
    localparam int GRID_DIM        = 256;
    localparam int GRID_W          = 9;

    localparam int CORDIC_STEPS    = 16;
    localparam int CORDIC_STAGES   = 4;
    localparam int STEPS_PER_STAGE = CORDIC_STEPS / CORDIC_STAGES;
    localparam int STEP_W          = $clog2(CORDIC_STEPS);

    localparam int ROT_W           = 20;
    localparam int TRIG_W          = 18;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic                    flip;
    } t_rot;

    typedef struct packed {
        logic [7:0]         col;
        logic [7:0]         row;
        logic [15:0]        score;
        logic [16:0]        w;
        logic [16:0]        h;
        logic signed [16:0] dx;
        logic signed [16:0] dt;
        logic signed [15:0] ang;
    } t_side;

    localparam logic signed [ROT_W-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150,
        20'sd4091,  20'sd2047,  20'sd1024,  20'sd512,
        20'sd256,   20'sd128,   20'sd64,    20'sd32,
        20'sd16,    20'sd8,     20'sd4,     20'sd2
    };

    localparam logic signed [ROT_W-1:0]  CORDIC_GAIN  = 20'sd39797;
    localparam logic signed [ROT_W-1:0]  PI_Q16       = 20'sd205887;
    localparam logic signed [ROT_W-1:0]  HALF_PI_Q16  = 20'sd102944;
    localparam logic signed [ROT_W-1:0]  NHALF_PI_Q16 = -20'sd102944;
    localparam logic signed [ROT_W-1:0]  TRIG_ONE_W   = 20'sd65536;
    localparam logic signed [ROT_W-1:0]  NTRIG_ONE_W  = -20'sd65536;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE     = 18'sd65536;
    localparam logic signed [TRIG_W-1:0] NTRIG_ONE    = -18'sd65536;

    localparam logic signed [21:0] DEG_FACTOR = 22'sd938734;

    // One rotation-mode step: rotate toward zero residual angle.
    function automatic t_rot cordic_step(input t_rot v, input t_step i);
        t_rot                    r;
        logic signed [ROT_W-1:0] dx;
        logic signed [ROT_W-1:0] dy;
        dx = v.y >>> i;
        dy = v.x >>> i;
        r  = v;
        if (!v.z[ROT_W-1]) begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - ATAN_Q16[i];
        end else begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + ATAN_Q16[i];
        end
        return r;
    endfunction

endpackage

// ===== sv/east_text_box_decode.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------------
// input    | i_valid / o_stall      | i_cell_col, i_cell_row, i_score, i_dist_*, i_angle_rad
// result   | o_valid / i_stall      | o_center_x/y, o_box_width/height, o_angle_deg, o_box_score
// config   | i_cfg_wr_en            | i_cfg_wr_data (score threshold)
//
// One word is taken per cycle while o_stall is low; a kept cell then travels to the output.
// It passes the input register, four CORDIC stages, the trig, multiply, sum and output stages.
// Cells below the threshold or outside the grid are taken and give no result.
// Reset clears all stage valid bits and loads the threshold 0.4 in Q0.16.
// A stall only holds full stages; any empty stage still takes the word behind it.
module east_text_box_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_cell_col,
    input  logic [7:0]         i_cell_row,
    input  logic [15:0]        i_score,
    input  logic [15:0]        i_dist_top,
    input  logic [15:0]        i_dist_right,
    input  logic [15:0]        i_dist_bottom,
    input  logic [15:0]        i_dist_left,
    input  logic signed [15:0] i_angle_rad,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [19:0] o_center_x,
    output logic signed [19:0] o_center_y,
    output logic [16:0]        o_box_width,
    output logic [16:0]        o_box_height,
    output logic signed [15:0] o_angle_deg,
    output logic [15:0]        o_box_score
);

    localparam int S_TRIG = etbd_pkg::CORDIC_STAGES + 1;
    localparam int S_PROD = S_TRIG + 1;
    localparam int S_SUM  = S_PROD + 1;
    localparam int S_OUT  = S_SUM + 1;
    localparam int NSTG   = S_OUT + 1;
    localparam int OFF_SH = 23;
    localparam logic [15:0] THRESH_RST = 16'd26214;
    localparam logic signed [39:0] CTR_HALF = 40'sd65536;
    localparam logic signed [37:0] DEG_HALF = 38'sd524288;

    logic [15:0]             r_thresh;
    logic [NSTG-1:0]         r_vld;
    logic [NSTG:0]           rdy;
    logic                    keep;
    etbd_pkg::t_side         r_side [NSTG];
    etbd_pkg::t_side         n_side [NSTG];
    etbd_pkg::t_rot          r_rot0;
    etbd_pkg::t_rot          n_rot0;
    etbd_pkg::t_rot          rot_end;
    logic signed [19:0]      z8;
    logic signed [19:0]      fx;
    logic signed [19:0]      fy;
    logic signed [17:0]      r_sin;
    logic signed [17:0]      r_cos;
    logic signed [34:0]      r_pxc;
    logic signed [34:0]      r_pxs;
    logic signed [34:0]      r_pyc;
    logic signed [34:0]      r_pys;
    logic signed [37:0]      r_deg_p;
    logic signed [39:0]      offx;
    logic signed [39:0]      offy;
    logic signed [39:0]      r_cx2;
    logic signed [39:0]      r_cy2;
    logic signed [17:0]      r_deg_r;
    logic signed [19:0]      r_cx;
    logic signed [19:0]      r_cy;
    logic signed [15:0]      r_deg;

    function automatic logic signed [17:0] clamp_trig(input logic signed [19:0] v);
        logic signed [17:0] r;
        if (v > etbd_pkg::TRIG_ONE_W) begin
            r = etbd_pkg::TRIG_ONE;
        end else if (v < etbd_pkg::NTRIG_ONE_W) begin
            r = etbd_pkg::NTRIG_ONE;
        end else begin
            r = 18'(v);
        end
        return r;
    endfunction

    function automatic logic signed [19:0] center_round(input logic signed [39:0] v);
        logic signed [39:0] s;
        logic signed [22:0] q;
        logic signed [19:0] r;
        s = (v + CTR_HALF) >>> 17;
        q = 23'(s);
        if (q > 23'sd524287) begin
            r = 20'sd524287;
        end else if (q < -23'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = 20'(q);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RST;
        end else if (i_cfg_wr_en) begin
            r_thresh <= i_cfg_wr_data;
        end
    end

    always_comb begin
        rdy[NSTG] = !i_stall;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[0];
    assign keep = i_valid
        && (etbd_pkg::GRID_W'(i_cell_col) < etbd_pkg::GRID_W'(etbd_pkg::GRID_DIM))
        && (etbd_pkg::GRID_W'(i_cell_row) < etbd_pkg::GRID_W'(etbd_pkg::GRID_DIM))
        && (i_score >= r_thresh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= keep;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        n_side[0].col   = i_cell_col;
        n_side[0].row   = i_cell_row;
        n_side[0].score = i_score;
        n_side[0].w     = 17'(i_dist_right) + 17'(i_dist_left);
        n_side[0].h     = 17'(i_dist_top) + 17'(i_dist_bottom);
        n_side[0].dx    = $signed({1'b0, i_dist_right}) - $signed({1'b0, i_dist_left});
        n_side[0].dt    = $signed({1'b0, i_dist_bottom}) - $signed({1'b0, i_dist_top});
        n_side[0].ang   = i_angle_rad;
        for (int k = 1; k < NSTG; k++) begin
            n_side[k] = r_side[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
                r_side[k] <= n_side[k];
            end
        end
    end

    // Fold the angle into the CORDIC range; the folded results are negated later.
    always_comb begin
        z8          = 20'(i_angle_rad) <<< 3;
        n_rot0.x    = etbd_pkg::CORDIC_GAIN;
        n_rot0.y    = '0;
        n_rot0.z    = z8;
        n_rot0.flip = 1'b0;
        if (z8 > etbd_pkg::HALF_PI_Q16) begin
            n_rot0.z    = z8 - etbd_pkg::PI_Q16;
            n_rot0.flip = 1'b1;
        end else if (z8 < etbd_pkg::NHALF_PI_Q16) begin
            n_rot0.z    = z8 + etbd_pkg::PI_Q16;
            n_rot0.flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_rot0 <= n_rot0;
        end
    end

    etbd_cordic u_cordic (
        .i_clk (i_clk),
        .i_adv (rdy[S_TRIG-1:1]),
        .i_rot (r_rot0),
        .o_rot (rot_end)
    );

    always_comb begin
        fx = rot_end.flip ? -rot_end.x : rot_end.x;
        fy = rot_end.flip ? -rot_end.y : rot_end.y;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[S_TRIG]) begin
            r_cos <= clamp_trig(fx);
            r_sin <= clamp_trig(fy);
        end
    end

    // With w = r + l and h = t + b the center terms reduce to two products per axis.
    always_ff @(posedge i_clk) begin
        if (rdy[S_PROD]) begin
            r_pxc   <= r_cos * r_side[S_TRIG].dx;
            r_pxs   <= r_sin * r_side[S_TRIG].dt;
            r_pyc   <= r_cos * r_side[S_TRIG].dt;
            r_pys   <= r_sin * r_side[S_TRIG].dx;
            r_deg_p <= r_side[S_TRIG].ang * etbd_pkg::DEG_FACTOR;
        end
    end

    always_comb begin
        offx = $signed(40'(r_side[S_PROD].col) * 40'(etbd_pkg::CELL_STRIDE)) <<< OFF_SH;
        offy = $signed(40'(r_side[S_PROD].row) * 40'(etbd_pkg::CELL_STRIDE)) <<< OFF_SH;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[S_SUM]) begin
            r_cx2   <= offx + 40'(r_pxc) + 40'(r_pxs);
            r_cy2   <= offy + 40'(r_pyc) - 40'(r_pys);
            r_deg_r <= 18'((DEG_HALF - r_deg_p) >>> 20);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[S_OUT]) begin
            r_cx <= center_round(r_cx2);
            r_cy <= center_round(r_cy2);
            if (r_deg_r > 18'sd32767) begin
                r_deg <= 16'sd32767;
            end else if (r_deg_r < -18'sd32768) begin
                r_deg <= -16'sd32768;
            end else begin
                r_deg <= 16'(r_deg_r);
            end
        end
    end

    assign o_valid      = r_vld[S_OUT];
    assign o_center_x   = r_cx;
    assign o_center_y   = r_cy;
    assign o_box_width  = r_side[S_OUT].w;
    assign o_box_height = r_side[S_OUT].h;
    assign o_angle_deg  = r_deg;
    assign o_box_score  = r_side[S_OUT].score;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("Input stalled while a pipeline stage is empty.");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !keep) |=> !r_vld[0])
        else $error("A rejected cell entered the pipeline.");

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && keep) |=> r_vld[0])
        else $error("A kept cell was lost at the input stage.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("Pipeline not empty after reset.");

endmodule

// ===== sv/etbd_cordic.sv =====
module etbd_cordic (
    input  logic                                i_clk,
    input  logic [etbd_pkg::CORDIC_STAGES-1:0]  i_adv,
    input  etbd_pkg::t_rot                      i_rot,
    output etbd_pkg::t_rot                      o_rot
);

    etbd_pkg::t_rot r_stg [etbd_pkg::CORDIC_STAGES];
    etbd_pkg::t_rot n_stg [etbd_pkg::CORDIC_STAGES];
    etbd_pkg::t_rot src   [etbd_pkg::CORDIC_STAGES];

    always_comb begin
        src[0] = i_rot;
        for (int k = 1; k < etbd_pkg::CORDIC_STAGES; k++) begin
            src[k] = r_stg[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < etbd_pkg::CORDIC_STAGES; k++) begin
            n_stg[k] = src[k];
            for (int j = 0; j < etbd_pkg::STEPS_PER_STAGE; j++) begin
                n_stg[k] = etbd_pkg::cordic_step(n_stg[k],
                    etbd_pkg::t_step'(k * etbd_pkg::STEPS_PER_STAGE + j));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < etbd_pkg::CORDIC_STAGES; k++) begin
            if (i_adv[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_rot = r_stg[etbd_pkg::CORDIC_STAGES-1];

endmodule
